>>> rtl/hkst_pkg.sv
// Shared types and constants for the hashed key set table.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package hkst_pkg;

	localparam int KEY_MOD    = 997;  // hash modulus
	localparam int REM_W      = 10;   // remainder width, holds 0..996; also the fold width
	localparam int FOLD_MUL   = (1 << REM_W) % KEY_MOD;  // weight of the bits above the fold
	localparam int HASH_STEPS = 7;    // six folds, the seventh reduces below the modulus
	localparam int HCNT_W     = 3;
	localparam int DATA_W     = 32;

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_HAS    = 3'd2,
		CMD_INC    = 3'd3,
		CMD_DEC    = 3'd4
	} command_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_SCAN,
		S_SHIFT,
		S_ADJ,
		S_RESP
	} state_t;

	// write action of the read-back stage
	typedef enum logic [1:0] {
		W_NONE,
		W_SHIFT,
		W_INC,
		W_DEC
	} wmode_t;

	typedef struct packed {
		logic    load;           // capture value, start hash, rewind pointer
		logic    hash_step;
		logic    rd_en;          // read entry at pointer, advance pointer
		logic    ptr_load_next;  // pointer to entry after the matching one
		wmode_t  wmode;
		logic    append;         // write key at the end of the list
		logic    cnt_inc;
		logic    cnt_dec;
		logic    res_load;
		status_t res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic hash_last;
		logic ptr_end;   // pointer reached entry count
		logic vld_s1;    // read data pending in stage one
		logic match;     // stage-one entry equals key
		logic full;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/hashed_key_set_table_top.sv
// Add, remove and contain fold the value to its key, then scan with one memory read per entry;
// remove then shifts the later entries down, and increment and decrement rewrite every entry.
// Other commands go straight to the result; every result may wait on m_tready.
// One item at a time; the next is taken in the cycle after its result is loaded,
// also while that result still waits. Stream ports around hkst_ctrl and hkst_dp.
// arst_n clears the entry count and control; entry memory is not cleared.
`default_nettype none

module hashed_key_set_table_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [2:0] command, [34:3] value, rest zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [1:0] status, [8:2] count, rest zero
);
	import hkst_pkg::*;

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [1:0] res_status;
	logic [6:0] res_count;

	hkst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.command   (s_tdata[2:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hkst_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (s_tdata[34:3]),
		.cmd        (cmd),
		.sts        (sts),
		.res_status (res_status),
		.res_count  (res_count)
	);

	assign m_tdata = {7'd0, res_count, res_status};

endmodule

`default_nettype wire

>>> rtl/hkst_dp.sv
// Datapath: hash unit, entry memory with its scan pipeline, count and result register.
// Depends on hkst_pkg; driven by hkst_ctrl.
`default_nettype none

module hkst_dp #(
	parameter int CAPACITY = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [31:0]      value,
	input  wire hkst_pkg::dp_cmd_t cmd,
	output hkst_pkg::dp_sts_t     sts,
	output logic [1:0]            res_status,
	output logic [6:0]            res_count
);
	import hkst_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [DATA_W-1:0] mem_q [CAPACITY];

	logic [DATA_W-1:0] mag_q;
	logic              sign_q;
	logic [REM_W-1:0]  rem_q;
	logic [HCNT_W-1:0] hcnt_q;
	logic [DATA_W-1:0] fold_hi;
	logic [DATA_W-1:0] fold_lo;
	logic [DATA_W-1:0] fold_n;
	logic [REM_W-1:0]  rem_n;
	logic [DATA_W-1:0] rem_ext;
	logic [DATA_W-1:0] key;

	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;
	logic [DATA_W-1:0] rd_data_s1;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [31:0]       cnt_ext;
	logic [1:0]        res_status_q;
	logic [6:0]        res_count_q;

	// 2^10 is 27 mod 997, so hi * 1024 + lo folds to hi * 27 + lo with the same
	// remainder; six folds bring the magnitude below 1024, one compare-subtract ends it
	assign fold_hi = {{REM_W{1'b0}}, mag_q[DATA_W-1:REM_W]};
	assign fold_lo = {{(DATA_W-REM_W){1'b0}}, mag_q[REM_W-1:0]};
	assign fold_n  = fold_hi * DATA_W'(FOLD_MUL) + fold_lo;
	assign rem_n   = (mag_q[REM_W-1:0] >= REM_W'(KEY_MOD)) ?
		mag_q[REM_W-1:0] - REM_W'(KEY_MOD) : mag_q[REM_W-1:0];
	assign rem_ext = {{(DATA_W-REM_W){1'b0}}, rem_q};
	assign key     = sign_q ? (32'd0 - rem_ext) : rem_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
		end else if (cmd.load) begin
			hcnt_q <= '0;
		end else if (cmd.hash_step) begin
			hcnt_q <= hcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sign_q <= value[31];
			mag_q  <= value[31] ? (32'd0 - value) : value;
			rem_q  <= '0;
		end else if (cmd.hash_step) begin
			mag_q <= fold_n;
			rem_q <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.ptr_load_next) begin
				ptr_q <= CW'(idx_s1) + 1'b1;
			end else if (cmd.rd_en) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			idx_s1 <= ptr_q[AW-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data_s1;
		case (cmd.wmode)
			W_SHIFT: begin
				wr_en   = vld_s1;
				wr_addr = idx_s1 - 1'b1;
			end
			W_INC: begin
				wr_en   = vld_s1;
				wr_data = rd_data_s1 + 1'b1;
			end
			W_DEC: begin
				wr_en   = vld_s1;
				wr_data = rd_data_s1 - 1'b1;
			end
			default: begin
			end
		endcase
		if (cmd.append) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[AW-1:0];
			wr_data = key;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[ptr_q[AW-1:0]];
		end
	end

	assign cnt_ext = 32'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_count_q  <= cnt_ext[6:0];
		end
	end

	assign res_status = res_status_q;
	assign res_count  = res_count_q;

	assign sts.hash_last = (hcnt_q == HCNT_W'(HASH_STEPS - 1));
	assign sts.ptr_end   = (ptr_q == cnt_q);
	assign sts.vld_s1    = vld_s1;
	assign sts.match     = vld_s1 && (rd_data_s1 == key);
	assign sts.full      = (cnt_q == CW'(CAPACITY));

endmodule

`default_nettype wire

>>> rtl/hkst_ctrl.sv
// Controller: sequences hashing, scanning, shifting and adjusting of entries.
// Depends on hkst_pkg; drives hkst_dp and the stream handshakes.
`default_nettype none

module hkst_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [2:0]       command,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire hkst_pkg::dp_sts_t sts,
	output hkst_pkg::dp_cmd_t     cmd
);
	import hkst_pkg::*;

	state_t      state_q, state_n;
	logic [2:0]  op_q;
	status_t     stat_q, stat_n;
	logic        out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= CMD_ADD;
			stat_q    <= ST_DONE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			stat_q  <= stat_n;
			if (cmd.load) begin
				op_q <= command;
			end
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

	always_comb begin
		state_n        = state_q;
		stat_n         = stat_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.wmode      = W_NONE;
		cmd.res_status = stat_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					stat_n   = ST_DONE;
					case (command)
						CMD_ADD, CMD_REMOVE, CMD_HAS: state_n = S_HASH;
						CMD_INC, CMD_DEC:             state_n = S_ADJ;
						default:                      state_n = S_RESP;
					endcase
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) begin
					state_n = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = !sts.ptr_end && !sts.match;
				if (sts.match) begin
					case (op_q)
						CMD_REMOVE: begin
							cmd.ptr_load_next = 1'b1;
							state_n           = S_SHIFT;
						end
						CMD_ADD: begin
							stat_n  = ST_MISS;
							state_n = S_RESP;
						end
						default: begin
							stat_n  = ST_DONE;
							state_n = S_RESP;
						end
					endcase
				end else if (sts.ptr_end && !sts.vld_s1) begin
					state_n = S_RESP;
					if (op_q == CMD_ADD) begin
						if (sts.full) begin
							stat_n = ST_FULL;
						end else begin
							cmd.append  = 1'b1;
							cmd.cnt_inc = 1'b1;
							stat_n      = ST_DONE;
						end
					end else begin
						stat_n = ST_MISS;
					end
				end
			end
			S_SHIFT: begin
				// entry i+1 read this cycle is written to i the next
				cmd.wmode = W_SHIFT;
				cmd.rd_en = !sts.ptr_end;
				if (sts.ptr_end && !sts.vld_s1) begin
					cmd.cnt_dec = 1'b1;
					stat_n      = ST_DONE;
					state_n     = S_RESP;
				end
			end
			S_ADJ: begin
				cmd.wmode = (op_q == CMD_INC) ? W_INC : W_DEC;
				cmd.rd_en = !sts.ptr_end;
				if (sts.ptr_end && !sts.vld_s1) begin
					stat_n  = ST_DONE;
					state_n = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_vld_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/hkst_chk.sv
// Port-level checker for the hashed key set table, bound to the top level.
// Depends on hkst_pkg.
`default_nettype none

module hkst_chk #(
	parameter int CAPACITY = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	import hkst_pkg::*;

	localparam logic [6:0] CAP7 = 7'(CAPACITY);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (CAPACITY < 128) |-> m_tdata[8:2] <= CAP7)
		else $error("count above capacity");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_FULL) |-> m_tdata[8:2] == CAP7)
		else $error("full status with table not full");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// one item in flight: input closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while busy");

endmodule

bind hashed_key_set_table_top hkst_chk #(
	.CAPACITY (CAPACITY)
) u_hkst_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> dv/hkst_checker.sv
// Scoreboard for the hashed key set table: watches both stream channels.
// Keeps its own copy of the key list, predicts each reply and compares it.
// Depends on hkst_pkg for the command and status codes.
`timescale 1ns / 1ps

module hkst_checker #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,   // [2:0] command, [34:3] value, rest zero
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,   // [1:0] status, [8:2] count, rest zero
	output int               fail_count,
	output int               pending
);
	import hkst_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [6:0] count;
	} reply_t;

	logic [31:0] stored_keys[$];
	reply_t      reply_q[$];

	// truncating remainder: the key keeps the sign of the value
	function automatic logic [31:0] hash_key(input logic [31:0] raw);
		int sv;
		sv = int'(raw);
		return sv % KEY_MOD;
	endfunction

	function automatic reply_t apply_command(input logic [2:0] cmd, input logic [31:0] raw);
		reply_t      r;
		logic [31:0] key;
		int          pos;
		r.status = ST_DONE;
		key      = hash_key(raw);
		pos      = -1;
		foreach (stored_keys[i])
			if (pos < 0 && stored_keys[i] == key)
				pos = i;
		case (cmd)
			CMD_ADD: begin
				if (pos >= 0)
					r.status = ST_MISS;
				else if (stored_keys.size() >= CAPACITY)
					r.status = ST_FULL;
				else
					stored_keys = {stored_keys, key};
			end
			CMD_REMOVE: begin
				if (pos < 0)
					r.status = ST_MISS;
				else
					stored_keys.delete(pos);
			end
			CMD_HAS: begin
				if (pos < 0)
					r.status = ST_MISS;
			end
			CMD_INC: begin
				foreach (stored_keys[i])
					stored_keys[i] = stored_keys[i] + 32'd1;
			end
			CMD_DEC: begin
				foreach (stored_keys[i])
					stored_keys[i] = stored_keys[i] - 32'd1;
			end
			default: ;  // spare codes leave the table alone
		endcase
		r.count = 7'(stored_keys.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			stored_keys.delete();
			reply_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tdata[1:0]);
				got.count  = m_tdata[8:2];
				if (reply_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected reply: status %0d count %0d",
							got.status, got.count);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (got.status !== want.status || got.count !== want.count) begin
						if (fail_count < 10)
							$display("reply mismatch: expected status %0d count %0d, got status %0d count %0d",
								want.status, want.count, m_tdata[1:0], m_tdata[8:2]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				reply_q = {reply_q, apply_command(s_tdata[2:0], s_tdata[34:3])};
			pending <= reply_q.size();
		end
	end

endmodule

>>> dv/tb.sv
// Testbench top for hashed_key_set_table_top: clock, reset, item stimulus and verdict.
// Depends on hkst_pkg, the block itself and hkst_checker for the predictions.
`timescale 1ns / 1ps

module tb;
	import hkst_pkg::*;

	localparam int CAPACITY = 64;
	localparam int LIMIT_NS = 5_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	int          fail_count;
	int          pending;
	int          items_sent = 0;

	hashed_key_set_table_top #(.CAPACITY(CAPACITY)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hkst_checker #(.CAPACITY(CAPACITY)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	// no idling on either side during this window of items
	function automatic bit steady_window();
		return items_sent >= 420 && items_sent < 520;
	endfunction

	// value whose hash lands on the given key, with a random multiple of the modulus
	function automatic logic [31:0] value_for_key(input int key);
		bit     neg;
		longint lim;
		longint mult;
		longint v;
		neg  = (key < 0) || (key == 0 && $urandom_range(1) == 1);
		lim  = neg ? 64'sd2147483648 + key : 64'sd2147483647 - key;
		mult = $urandom_range(32'(lim / KEY_MOD));
		v    = neg ? key - mult * KEY_MOD : key + mult * KEY_MOD;
		return v[31:0];
	endfunction

	task automatic send_item(input logic [2:0] cmd, input logic [31:0] val);
		if (!steady_window())
			while ($urandom_range(99) < 11) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, val, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic random_item(input int spread, input int add_pct, input int rem_pct);
		int          roll;
		logic [2:0]  cmd;
		logic [31:0] val;
		roll = $urandom_range(99);
		if (roll < add_pct)
			cmd = CMD_ADD;
		else if (roll < add_pct + rem_pct)
			cmd = CMD_REMOVE;
		else if (roll < 88)
			cmd = CMD_HAS;
		else if (roll < 93)
			cmd = CMD_INC;
		else if (roll < 98)
			cmd = CMD_DEC;
		else
			cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		if ($urandom_range(9) == 0)
			val = $urandom;
		else
			val = value_for_key(int'($urandom_range(2 * spread)) - spread);
		send_item(cmd, val);
	endtask

	// one edge first so the checker has seen the last accepted item
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin : sink
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && items_sent >= 120) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady_window())
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 11);
		end
	end

	initial begin : source
		int fill_keys[$];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, hash extremes, duplicates, shifted keys, spare codes
		send_item(CMD_INC,    32'h0);
		send_item(CMD_DEC,    32'h0);
		send_item(CMD_HAS,    32'h0);
		send_item(CMD_REMOVE, 32'd5);
		send_item(CMD_ADD,    32'h0000_0000);
		send_item(CMD_ADD,    32'h7FFF_FFFF);
		send_item(CMD_ADD,    32'h8000_0000);
		send_item(CMD_ADD,    32'hFFFF_FFFF);
		send_item(CMD_ADD,    32'd997);
		send_item(CMD_ADD,    -32'sd997);
		send_item(CMD_HAS,    32'd1994);
		send_item(CMD_HAS,    32'd996);
		send_item(CMD_HAS,    -32'sd996);
		send_item(CMD_INC,    32'hFFFF_FFFF);
		send_item(CMD_HAS,    32'h0);
		send_item(CMD_ADD,    32'd1);
		send_item(CMD_DEC,    32'h0);
		send_item(CMD_REMOVE, 32'h0);
		send_item(CMD_REMOVE, 32'hFFFF_FFFF);
		send_item(CMD_HAS,    32'h7FFF_FFFF);
		send_item(CMD_SPARE_FIRST, 32'h0);
		send_item(CMD_SPARE_MID,   32'h1234_5678);
		send_item(CMD_SPARE_LAST,  32'hFFFF_FFFF);
		send_item(CMD_REMOVE, 32'h7FFF_FFFF);
		send_item(CMD_REMOVE, 32'h8000_0000);

		// small key pool so lookups and removes hit often
		repeat (150) random_item(6, 35, 20);

		// more distinct keys than the table holds, then adds against a full table
		for (int k = -40; k < 30; k++)
			fill_keys = {fill_keys, k};
		fill_keys.shuffle();
		foreach (fill_keys[i])
			send_item(CMD_ADD, value_for_key(fill_keys[i]));
		repeat (15) random_item(40, 80, 0);

		// drain the table back down
		repeat (100) random_item(40, 10, 55);

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (265) random_item(40, 30, 30);

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> hashed_key_set_table_top.f
rtl/hkst_pkg.sv
rtl/hkst_dp.sv
rtl/hkst_ctrl.sv
rtl/hashed_key_set_table_top.sv
rtl/hkst_chk.sv
dv/hkst_checker.sv
dv/tb.sv
